@@ hw/rtl/tafp_pkg.sv @@
// Package: character codes, tag codes and channel decode for the tagged ASCII field parser.
`timescale 1ns / 1ps
`default_nettype none
package tafp_pkg;

    localparam int unsigned STATE_W = 9;
    localparam int unsigned CHAN_W  = 4;
    localparam int unsigned POS_W   = 3;
    localparam int unsigned CHAR_W  = 8;

    typedef logic [STATE_W-1:0] t_state;
    typedef logic [CHAN_W-1:0]  t_chan;
    typedef logic [CHAR_W-1:0]  t_char;

    localparam t_char CHAR_ZERO  = 8'h30;
    localparam t_char CHAR_NINE  = 8'h39;
    localparam t_char CHAR_DOT   = 8'h2E;
    localparam t_char CHAR_MINUS = 8'h2D;

    localparam t_state ST_COLLECT = 9'd0;
    localparam t_state TAG_A      = 9'd97;
    localparam t_state TAG_G      = 9'd103;
    localparam t_state TAG_E      = 9'd101;
    localparam t_state TAG_C      = 9'd99;
    localparam t_state AX_X       = 9'd120;
    localparam t_state AX_Y       = 9'd121;
    localparam t_state AX_Z       = 9'd122;
    localparam t_state AX_R       = 9'd114;
    localparam t_state AX_P       = 9'd112;

    localparam t_chan CH_ACC_X  = 4'd0;
    localparam t_chan CH_ACC_Y  = 4'd1;
    localparam t_chan CH_ACC_Z  = 4'd2;
    localparam t_chan CH_GYR_X  = 4'd3;
    localparam t_chan CH_GYR_Y  = 4'd4;
    localparam t_chan CH_GYR_Z  = 4'd5;
    localparam t_chan CH_ROLL   = 4'd6;
    localparam t_chan CH_YAW    = 4'd7;
    localparam t_chan CH_PITCH  = 4'd8;
    localparam t_chan CH_COMP   = 4'd9;
    localparam t_chan NO_CHANNEL = 4'd15;

    // Map a parse state to the channel it commits to.
    function automatic t_chan commit_channel(input t_state s);
        t_chan ch;
        ch = NO_CHANNEL;
        if (s == TAG_A + AX_X)      ch = CH_ACC_X;
        else if (s == TAG_A + AX_Y) ch = CH_ACC_Y;
        else if (s == TAG_A + AX_Z) ch = CH_ACC_Z;
        else if (s == TAG_G + AX_X) ch = CH_GYR_X;
        else if (s == TAG_G + AX_Y) ch = CH_GYR_Y;
        else if (s == TAG_G + AX_Z) ch = CH_GYR_Z;
        else if (s == TAG_E + AX_R) ch = CH_ROLL;
        else if (s == TAG_E + AX_Y) ch = CH_YAW;
        else if (s == TAG_E + AX_P) ch = CH_PITCH;
        else if (s == TAG_C)        ch = CH_COMP;
        return ch;
    endfunction

    function automatic logic is_value_char(input t_char c);
        return ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) || (c == CHAR_DOT) || (c == CHAR_MINUS);
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/tafp_in_if.sv @@
// Interface: input byte channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface tafp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/tafp_out_if.sv @@
// Interface: output character channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface tafp_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] channel;
    logic [2:0] char_pos;
    logic [7:0] char_value;
    logic       last;

    modport source (output valid, output channel, output char_pos, output char_value,
                    output last, input ready);
    modport sink   (input valid, input channel, input char_pos, input char_value,
                    input last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/tafp_fifo.sv @@
// Two-entry queue of commit records between the parser front and the emitter back.
`timescale 1ns / 1ps
`default_nettype none
module tafp_fifo #(
    parameter int unsigned WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_push_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_pop_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full     = (r_count == 2'd2);
    assign o_empty    = (r_count == 2'd0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_pop)  r_rd_ptr <= ~r_rd_ptr;
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/tafp_front.sv @@
// Parser front: classify each byte, track tag state, fill the value buffer, queue commits.
`timescale 1ns / 1ps
`default_nettype none
module tafp_front #(
    parameter int unsigned BUF_LEN = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    tafp_in_if.sink                           i_in,
    input  wire logic                         i_q_full,
    output logic                              o_push,
    output logic [tafp_pkg::CHAN_W+BUF_LEN*8-1:0] o_push_data
);
    import tafp_pkg::*;

    localparam int unsigned FW = $clog2(BUF_LEN + 1);
    localparam int unsigned IW = (BUF_LEN > 1) ? $clog2(BUF_LEN) : 1;
    localparam logic [FW-1:0] FILL_FULL = FW'(BUF_LEN);

    t_state        r_state, n_state;
    t_char         r_buf [BUF_LEN];
    logic [FW-1:0] r_fill, n_fill;
    logic          accept;
    logic          is_tag_head;
    t_chan         ch;
    logic          commit;
    logic          refill;
    logic          store;
    logic [BUF_LEN*8-1:0] snap;

    assign i_in.ready  = !i_q_full;
    assign accept      = i_in.valid && i_in.ready;
    assign is_tag_head = (r_state == TAG_A) || (r_state == TAG_G) || (r_state == TAG_E);
    assign ch          = commit_channel(r_state);

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        commit  = 1'b0;
        refill  = 1'b0;
        store   = 1'b0;
        if (accept) begin
            if (is_tag_head) begin
                n_state = r_state + t_state'(i_in.rx_byte);
            end else if (ch != NO_CHANNEL) begin
                commit  = 1'b1;
                refill  = 1'b1;
                n_fill  = '0;
                n_state = ST_COLLECT;
            end else if (is_value_char(i_in.rx_byte)) begin
                if (r_fill >= FILL_FULL) begin
                    // overflow: refill and drop the byte
                    refill = 1'b1;
                    n_fill = '0;
                end else begin
                    store  = 1'b1;
                    n_fill = r_fill + FW'(1);
                end
            end else begin
                n_state = t_state'(i_in.rx_byte);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < BUF_LEN; k++) begin
            snap[k*8 +: 8] = r_buf[k];
        end
    end

    assign o_push      = commit;
    assign o_push_data = {ch, snap};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
            r_fill  <= '0;
            for (int k = 0; k < BUF_LEN; k++) r_buf[k] <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (refill) begin
                for (int k = 0; k < BUF_LEN; k++) r_buf[k] <= CHAR_ZERO;
            end else if (store) begin
                r_buf[r_fill[IW-1:0]] <= i_in.rx_byte;
            end
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/tafp_back.sv @@
// Emitter back: pop a commit record and send its characters through an output register.
`timescale 1ns / 1ps
`default_nettype none
module tafp_back #(
    parameter int unsigned BUF_LEN = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_q_empty,
    input  wire logic [tafp_pkg::CHAN_W+BUF_LEN*8-1:0] i_q_data,
    output logic                                  o_pop,
    tafp_out_if.source                            o_out
);
    import tafp_pkg::*;

    localparam int unsigned PW = (BUF_LEN > 1) ? $clog2(BUF_LEN) : 1;
    localparam logic [PW-1:0] POS_LAST = PW'(BUF_LEN - 1);

    logic [BUF_LEN*8-1:0] r_data;
    t_chan                r_ch;
    logic                 r_busy;
    logic [PW-1:0]        r_pos;
    logic                 r_ov;
    t_chan                r_o_ch;
    logic [POS_W-1:0]     r_o_pos;
    t_char                r_o_val;
    logic                 r_o_last;
    logic                 load_slot;
    logic [PW+POS_W-1:0]  pos_ext;

    assign load_slot = !r_ov || o_out.ready;
    assign o_pop     = !r_busy && !i_q_empty;
    assign pos_ext   = {{POS_W{1'b0}}, r_pos};

    always_ff @(posedge i_clk) begin
        if (load_slot && r_busy) begin
            r_o_ch   <= r_ch;
            r_o_pos  <= pos_ext[POS_W-1:0];
            r_o_val  <= r_data[r_pos*8 +: 8];
            r_o_last <= (r_pos == POS_LAST);
        end
        if (o_pop) begin
            r_ch   <= i_q_data[CHAN_W+BUF_LEN*8-1 -: CHAN_W];
            r_data <= i_q_data[BUF_LEN*8-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (load_slot) r_ov <= r_busy;
            if (o_pop) begin
                r_busy <= 1'b1;
                r_pos  <= '0;
            end else if (load_slot && r_busy) begin
                // advance through the record, release it after the last character
                if (r_pos == POS_LAST) begin
                    r_busy <= 1'b0;
                end else begin
                    r_pos <= r_pos + PW'(1);
                end
            end
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.channel    = r_o_ch;
    assign o_out.char_pos   = r_o_pos;
    assign o_out.char_value = r_o_val;
    assign o_out.last       = r_o_last;
endmodule
`default_nettype wire

@@ hw/rtl/tagged_ascii_field_parser_top.sv @@
// Top level of the tagged ASCII field parser: front, commit queue and emitter back.
//
// Usage:
//   i_in carries one received byte per transaction (rx_byte). Value characters
//   ('0'-'9', '.', '-') fill an internal buffer; letters set the parse state,
//   and a tag letter plus axis letter (or 'c' for compass) names a channel.
//   The byte after a complete tag commits the buffer.
//   o_out carries one buffer character per transaction: channel, char_pos,
//   char_value and last, with last set on character BUF_LEN-1.
// Throughput and flow:
//   The front takes one byte per cycle while the two-entry commit queue has
//   room. A commit passes through the queue, the emitter's record register
//   and its output register before it reaches o_out, and the emitter then
//   sends BUF_LEN characters, one per cycle when o_out.ready stays high,
//   followed by an idle gap while it pops the next record.
// Stalls:
//   A low o_out.ready holds the output register; the front keeps parsing
//   until two commits are waiting, then drops i_in.ready.
// Reset:
//   i_rst_n (synchronous, active low) empties the queue, clears the parse
//   state and fill index, and sets the buffer to all 0x00 bytes.
`timescale 1ns / 1ps
`default_nettype none
module tagged_ascii_field_parser_top #(
    parameter int unsigned BUF_LEN = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tafp_in_if.sink    i_in,
    tafp_out_if.source o_out
);
    import tafp_pkg::*;

    localparam int unsigned REC_W = CHAN_W + BUF_LEN * 8;

    // commit record: channel on top, buffer snapshot below
    logic             push;
    logic [REC_W-1:0] push_data;
    logic             q_full;
    logic             pop;
    logic             q_empty;
    logic [REC_W-1:0] q_data;

    tafp_front #(.BUF_LEN(BUF_LEN)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    tafp_fifo #(.WIDTH(REC_W)) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_empty     (q_empty),
        .o_pop_data  (q_data)
    );

    tafp_back #(.BUF_LEN(BUF_LEN)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_pop     (pop),
        .o_out     (o_out)
    );
endmodule
`default_nettype wire

@@ tb/tafp_field_checker.sv @@
// Checker: watches both channels, predicts the committed characters and compares them.
`timescale 1ns / 1ps
module tafp_field_checker #(
    parameter int unsigned BUF_LEN = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tafp_in_if         i_in_mon,
    tafp_out_if        i_out_mon,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_commit_count,
    output int         o_overflow_count,
    output logic [9:0] o_channel_mask
);
    import tafp_pkg::*;

    typedef struct packed {
        t_chan            channel;
        logic [POS_W-1:0] pos;
        t_char            value;
        logic             last;
    } t_out_char;

    t_out_char  expected_chars[$];
    t_state     parse_st;
    t_char      value_buf [BUF_LEN];
    logic [5:0] fill_idx;
    int         fails = 0;
    int         commits = 0;
    int         overflows = 0;
    logic [9:0] chan_seen = '0;

    function automatic t_chan tag_channel(input t_state s);
        case (s)
            t_state'(TAG_A + AX_X): return CH_ACC_X;
            t_state'(TAG_A + AX_Y): return CH_ACC_Y;
            t_state'(TAG_A + AX_Z): return CH_ACC_Z;
            t_state'(TAG_G + AX_X): return CH_GYR_X;
            t_state'(TAG_G + AX_Y): return CH_GYR_Y;
            t_state'(TAG_G + AX_Z): return CH_GYR_Z;
            t_state'(TAG_E + AX_R): return CH_ROLL;
            t_state'(TAG_E + AX_Y): return CH_YAW;
            t_state'(TAG_E + AX_P): return CH_PITCH;
            TAG_C:                  return CH_COMP;
            default:                return NO_CHANNEL;
        endcase
    endfunction

    // Advance the parser by one byte; a commit queues BUF_LEN characters.
    task automatic parse_byte(input t_char c);
        t_chan     ch;
        t_out_char rec;
        ch = tag_channel(parse_st);
        if (parse_st == TAG_A || parse_st == TAG_G || parse_st == TAG_E) begin
            parse_st = parse_st + t_state'(c);
        end else if (ch != NO_CHANNEL) begin
            for (int k = 0; k < BUF_LEN; k++) begin
                rec.channel = ch;
                rec.pos     = k[POS_W-1:0];
                rec.value   = value_buf[k];
                rec.last    = (k == BUF_LEN - 1);
                expected_chars.push_back(rec);
                value_buf[k] = CHAR_ZERO;
            end
            fill_idx = '0;
            parse_st = ST_COLLECT;
            commits++;
            chan_seen[ch] = 1'b1;
        end else if (c inside {[CHAR_ZERO:CHAR_NINE], CHAR_DOT, CHAR_MINUS}) begin
            if (fill_idx >= BUF_LEN) begin
                foreach (value_buf[k]) value_buf[k] = CHAR_ZERO;
                fill_idx = '0;
                overflows++;
            end else begin
                value_buf[fill_idx] = c;
                fill_idx++;
            end
        end else begin
            parse_st = t_state'(c);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t checker: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_char want;
        if (!i_rst_n) begin
            parse_st = ST_COLLECT;
            foreach (value_buf[k]) value_buf[k] = '0;
            fill_idx = '0;
            expected_chars.delete();
        end else begin
            // outputs first: a byte accepted at this edge cannot reach o_out yet
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_chars.size() == 0) begin
                    $display({"%0t checker: unexpected character, expected none, ",
                              "actual ch %0d pos %0d val %0d last %0d"},
                             $time, i_out_mon.channel, i_out_mon.char_pos,
                             i_out_mon.char_value, i_out_mon.last);
                    fails++;
                end else begin
                    want = expected_chars.pop_front();
                    check_field("channel", want.channel, i_out_mon.channel);
                    check_field("char_pos", want.pos, i_out_mon.char_pos);
                    check_field("char_value", want.value, i_out_mon.char_value);
                    check_field("last", want.last, i_out_mon.last);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) parse_byte(i_in_mon.rx_byte);
        end
        o_fail_count     <= fails;
        o_pending        <= expected_chars.size();
        o_commit_count   <= commits;
        o_overflow_count <= overflows;
        o_channel_mask   <= chan_seen;
    end

endmodule

@@ tb/tb.sv @@
// Testbench top: clock, reset, byte stimulus, output back-pressure and the verdict.
`timescale 1ns / 1ps
module tb;
    import tafp_pkg::*;

    localparam int unsigned BUF_LEN = 8;
    // Watchdog limit for the whole run, with plenty of margin over the slowest legal run.
    localparam int CYCLE_LIMIT  = 300000;
    localparam int LONG_HOLD    = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_BYTES  = 95;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tafp_in_if  in_ch ();
    tafp_out_if out_ch ();

    // Pacing knobs. rx_idle_pct and hold_req are read by the receiver process,
    // so write them with nonblocking assignments only.
    int tx_idle_pct = 14;
    int rx_idle_pct = 54;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int bytes_sent  = 0;
    int cycle_count = 0;

    int         fail_count;
    int         pending;
    int         commit_count;
    int         overflow_count;
    logic [9:0] channel_mask;

    always #6 clk = ~clk;

    tagged_ascii_field_parser_top #(
        .BUF_LEN (BUF_LEN)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tafp_field_checker #(
        .BUF_LEN (BUF_LEN)
    ) i_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_mon         (in_ch),
        .i_out_mon        (out_ch),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_commit_count   (commit_count),
        .o_overflow_count (overflow_count),
        .o_channel_mask   (channel_mask)
    );

    // Watchdog: end the run if the block hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Receiver: random ready, plus a long hold-off counted here whenever the
    // stimulus bumps hold_req.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one byte, with random idle cycles first; return at the edge of the
    // transaction. Junk goes on rx_byte while valid is low.
    task automatic send_byte(input t_char b);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid   <= 1'b0;
            in_ch.rx_byte <= t_char'($urandom);
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    // Drop valid and hold until every predicted character has come out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic t_char rand_value_char();
        int idx;
        idx = $urandom_range(11);
        if (idx < 10) return CHAR_ZERO + t_char'(idx);
        return (idx == 10) ? CHAR_DOT : CHAR_MINUS;
    endfunction

    // Send the tag for channel k: lead letter plus axis, or the compass letter alone.
    task automatic send_tag(input int k);
        t_state lead;
        t_state axis;
        lead = TAG_A;
        axis = AX_X;
        case (k)
            0: begin lead = TAG_A; axis = AX_X; end
            1: begin lead = TAG_A; axis = AX_Y; end
            2: begin lead = TAG_A; axis = AX_Z; end
            3: begin lead = TAG_G; axis = AX_X; end
            4: begin lead = TAG_G; axis = AX_Y; end
            5: begin lead = TAG_G; axis = AX_Z; end
            6: begin lead = TAG_E; axis = AX_R; end
            7: begin lead = TAG_E; axis = AX_Y; end
            8: begin lead = TAG_E; axis = AX_P; end
            default: lead = TAG_C;
        endcase
        send_byte(t_char'(lead));
        if (lead != TAG_C) send_byte(t_char'(axis));
    endtask

    // Well-formed record: value characters (sometimes enough to overflow),
    // a tag, then any byte to commit.
    task automatic send_record();
        int n;
        n = ($urandom_range(5) == 0) ? $urandom_range(14, 9) : $urandom_range(8);
        repeat (n) send_byte(rand_value_char());
        send_tag($urandom_range(9));
        send_byte(t_char'($urandom_range(255)));
    endtask

    // Broken record: either a lead letter plus an arbitrary byte (tag sums that
    // may collide with other codes), or a value cut off by a tag that never completes.
    task automatic send_broken();
        if ($urandom_range(1) == 0) begin
            send_byte(t_char'($urandom_range(1) ? TAG_A : TAG_G));
            send_byte(t_char'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(rand_value_char());
            send_byte(t_char'(TAG_E));
            send_byte(rand_value_char());
        end
    endtask

    task automatic run_random(input int n);
        int start;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < n) begin
            pick = $urandom_range(99);
            if (pick < 70)      send_record();
            else if (pick < 85) send_broken();
            else repeat ($urandom_range(1, 4)) send_byte(t_char'($urandom_range(255)));
        end
    endtask

    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.rx_byte <= '0;
        rst_n         <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: commit straight after reset, so the untouched buffer goes
        // out as 0x00 bytes on the compass channel.
        send_byte(t_char'(TAG_C));
        send_byte(t_char'(AX_Z));
        // Short signed decimal to accel x, committed by an all-ones byte.
        send_byte(CHAR_MINUS);
        send_byte(CHAR_NINE);
        send_byte(CHAR_DOT);
        send_byte(CHAR_ZERO);
        send_byte(t_char'(TAG_A));
        send_byte(t_char'(AX_X));
        send_byte(8'hFF);
        // Nine digits: the ninth overflows, refills with '0' and is dropped.
        repeat (8) send_byte(CHAR_ZERO + 8'd1);
        send_byte(CHAR_ZERO + 8'd2);
        // Pitch committed by a zero byte, then gyro z by a top-bit byte.
        send_byte(t_char'(TAG_E));
        send_byte(t_char'(AX_P));
        send_byte(8'h00);
        send_byte(t_char'(TAG_G));
        send_byte(t_char'(AX_Z));
        send_byte(8'h80);

        // Pressure: hold the output off for a long stretch while records keep
        // coming back to back, so the commit queue fills and i_in.ready drops.
        tx_idle_pct = 0;
        hold_req <= hold_req + 1;
        repeat (6) send_record();

        // Phase one: sender idles a little, receiver a lot.
        tx_idle_pct = 14;
        run_random(PHASE_BYTES);
        wait_drained();

        // Phase two: the other way round.
        tx_idle_pct = 54;
        rx_idle_pct <= 14;
        run_random(PHASE_BYTES);
        wait_drained();

        // Phase three: full rate on both sides.
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        run_random(PHASE_BYTES);
        wait_drained();

        // Catch any stray character after the last commit.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d bytes, %0d commits, %0d buffer overflows, channel mask %b",
                 bytes_sent, commit_count, overflow_count, channel_mask);
        $display("three pacing phases plus a %0d-cycle output hold-off with input back-pressure",
                 LONG_HOLD);
        if (fail_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
